[design/loct_pkg.sv]
package loct_pkg;

    localparam int LEN_W     = 20;
    localparam int KEY_OUT_W = 32;
    localparam int SLOT_W    = 4;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(102400);

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    // scan token control bits, passed cell to cell
    typedef struct packed {
        logic valid;
        logic match;
        logic empty;
        logic have_min;
    } t_flags;

    // write strobe broadcast to the cells
    typedef struct packed {
        logic we;
        logic set_key;
    } t_wr;

endpackage

[design/lru_object_cache_tags.sv]
// channel   valid     ready     payload
// request   i_valid   o_ready   i_cmd, i_key, i_obj_len
// result    o_valid   i_ready   o_hit, o_slot, o_rejected, o_evicted, o_evicted_key
// config    i_cfg_we  -         i_cfg_data (max_object_len)
//
// One item at a time: the next request is taken only after the last result is loaded into
// the output register. The scan token walks the row of entry cells, one cell per cycle.
// Reset empties all entries and clears the timestamp; no clearing pass.
// A result waiting on i_ready stalls the next request only after its scan ends.
module lru_object_cache_tags
    import loct_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int STAMP_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [KEY_OUT_W-1:0] i_key,
    input  logic [LEN_W-1:0]     i_obj_len,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_rejected,
    output logic                 o_evicted,
    output logic [KEY_OUT_W-1:0] o_evicted_key,
    input  logic                 i_cfg_we,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic [STAMP_BITS-1:0] r_time;
    logic [LEN_W-1:0]      r_max_len;
    t_cmd                  r_cmd;
    logic                  r_reject;
    logic [STAMP_BITS-1:0] r_req_stamp;

    logic                  r_res_hit;
    logic [IDX_W-1:0]      r_res_slot;
    logic                  r_res_evicted;
    logic [KEY_BITS-1:0]   r_res_ekey;

    logic                  r_o_valid;
    logic                  r_o_hit;
    logic [SLOT_W-1:0]     r_o_slot;
    logic                  r_o_rejected;
    logic                  r_o_evicted;
    logic [KEY_OUT_W-1:0]  r_o_ekey;

    t_flags                c_flags     [NUM_ENTRIES+1];
    logic [KEY_BITS-1:0]   c_key       [NUM_ENTRIES+1];
    logic [IDX_W-1:0]      c_match_idx [NUM_ENTRIES+1];
    logic [IDX_W-1:0]      c_empty_idx [NUM_ENTRIES+1];
    logic [IDX_W-1:0]      c_min_idx   [NUM_ENTRIES+1];
    logic [STAMP_BITS-1:0] c_min_stamp [NUM_ENTRIES+1];
    logic [KEY_BITS-1:0]   c_min_key   [NUM_ENTRIES+1];

    logic                  w_accept;
    logic                  w_done;
    logic                  w_o_load;
    logic [STAMP_BITS-1:0] n_time;
    t_wr                   n_wr;
    logic [IDX_W-1:0]      n_wr_idx;
    logic                  n_hit;
    logic                  n_evicted;
    t_flags                tail;

    assign w_accept = i_valid && o_ready;
    assign tail     = c_flags[NUM_ENTRIES];
    assign w_done   = (r_state == ST_SCAN) && tail.valid;
    assign w_o_load = (r_state == ST_DONE) && (!r_o_valid || i_ready);
    assign n_time   = (r_time == '1) ? r_time : r_time + 1'b1;

    // token head
    always_comb begin
        c_flags[0]       = '0;
        c_flags[0].valid = w_accept;
        c_key[0]         = KEY_BITS'(i_key);
        c_match_idx[0]   = '0;
        c_empty_idx[0]   = '0;
        c_min_idx[0]     = '0;
        c_min_stamp[0]   = '0;
        c_min_key[0]     = '0;
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        loct_cell #(
            .IDX_W      (IDX_W),
            .KEY_BITS   (KEY_BITS),
            .STAMP_BITS (STAMP_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_flags     (c_flags[g]),
            .i_key       (c_key[g]),
            .i_match_idx (c_match_idx[g]),
            .i_empty_idx (c_empty_idx[g]),
            .i_min_idx   (c_min_idx[g]),
            .i_min_stamp (c_min_stamp[g]),
            .i_min_key   (c_min_key[g]),
            .o_flags     (c_flags[g+1]),
            .o_key       (c_key[g+1]),
            .o_match_idx (c_match_idx[g+1]),
            .o_empty_idx (c_empty_idx[g+1]),
            .o_min_idx   (c_min_idx[g+1]),
            .o_min_stamp (c_min_stamp[g+1]),
            .o_min_key   (c_min_key[g+1]),
            .i_wr        (n_wr),
            .i_wr_idx    (n_wr_idx),
            .i_wr_key    (c_key[NUM_ENTRIES]),
            .i_wr_stamp  (r_req_stamp)
        );
    end

    // decision at token exit
    always_comb begin
        n_wr      = '0;
        n_wr_idx  = c_match_idx[NUM_ENTRIES];
        n_hit     = 1'b0;
        n_evicted = 1'b0;
        if (r_cmd == CMD_LOOKUP) begin
            n_hit   = tail.match;
            n_wr.we = w_done && tail.match;
        end else if (!r_reject) begin
            n_wr.we = w_done;
            if (tail.match) begin
                n_hit = 1'b1;
            end else if (tail.empty) begin
                n_wr_idx     = c_empty_idx[NUM_ENTRIES];
                n_wr.set_key = 1'b1;
            end else begin
                n_wr_idx     = c_min_idx[NUM_ENTRIES];
                n_wr.set_key = 1'b1;
                n_evicted    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_time    <= '0;
            r_max_len <= MAX_LEN_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (w_o_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= t_cmd'(i_cmd);
                        r_reject <= (t_cmd'(i_cmd) == CMD_INSERT) && (i_obj_len > r_max_len);
                        if (t_cmd'(i_cmd) == CMD_LOOKUP) begin
                            r_time      <= n_time;
                            r_req_stamp <= n_time;
                        end else begin
                            r_req_stamp <= r_time;
                        end
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_done) begin
                        r_res_hit     <= n_hit;
                        r_res_slot    <= (n_wr.we || n_hit) ? n_wr_idx : '0;
                        r_res_evicted <= n_evicted;
                        r_res_ekey    <= n_evicted ? c_min_key[NUM_ENTRIES] : '0;
                        r_state       <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_o_load) begin
                        r_o_hit      <= r_res_hit;
                        r_o_slot     <= SLOT_W'(r_res_slot);
                        r_o_rejected <= (r_cmd == CMD_INSERT) && r_reject;
                        r_o_evicted  <= r_res_evicted;
                        r_o_ekey     <= KEY_OUT_W'(r_res_ekey);
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_hit         = r_o_hit;
    assign o_slot        = r_o_slot;
    assign o_rejected    = r_o_rejected;
    assign o_evicted     = r_o_evicted;
    assign o_evicted_key = r_o_ekey;

endmodule

[design/loct_cell.sv]
module loct_cell
    import loct_pkg::*;
#(
    parameter int IDX_W      = 4,
    parameter int KEY_BITS   = 32,
    parameter int STAMP_BITS = 32,
    parameter int CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_flags                i_flags,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [IDX_W-1:0]      i_match_idx,
    input  logic [IDX_W-1:0]      i_empty_idx,
    input  logic [IDX_W-1:0]      i_min_idx,
    input  logic [STAMP_BITS-1:0] i_min_stamp,
    input  logic [KEY_BITS-1:0]   i_min_key,
    output t_flags                o_flags,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [IDX_W-1:0]      o_match_idx,
    output logic [IDX_W-1:0]      o_empty_idx,
    output logic [IDX_W-1:0]      o_min_idx,
    output logic [STAMP_BITS-1:0] o_min_stamp,
    output logic [KEY_BITS-1:0]   o_min_key,
    input  t_wr                   i_wr,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  logic [KEY_BITS-1:0]   i_wr_key,
    input  logic [STAMP_BITS-1:0] i_wr_stamp
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [STAMP_BITS-1:0] r_stamp;

    t_flags                r_flags;
    logic [KEY_BITS-1:0]   r_tok_key;
    logic [IDX_W-1:0]      r_match_idx;
    logic [IDX_W-1:0]      r_empty_idx;
    logic [IDX_W-1:0]      r_min_idx;
    logic [STAMP_BITS-1:0] r_min_stamp;
    logic [KEY_BITS-1:0]   r_min_key;

    t_flags                n_flags;
    logic                  w_hit_here;
    logic                  w_take_min;
    logic                  w_wr_here;

    assign w_hit_here = r_valid && (r_key == i_key);
    assign w_take_min = !i_flags.have_min || (r_stamp < i_min_stamp);
    assign w_wr_here  = i_wr.we && (i_wr_idx == MY_IDX);

    always_comb begin
        n_flags          = i_flags;
        n_flags.match    = i_flags.match | w_hit_here;
        n_flags.empty    = i_flags.empty | !r_valid;
        n_flags.have_min = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
            if (w_wr_here) begin
                r_stamp <= i_wr_stamp;
                if (i_wr.set_key) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_here && i_wr.set_key) begin
            r_key <= i_wr_key;
        end
        r_tok_key   <= i_key;
        r_match_idx <= i_flags.match ? i_match_idx : MY_IDX;
        r_empty_idx <= i_flags.empty ? i_empty_idx : MY_IDX;
        r_min_idx   <= w_take_min ? MY_IDX  : i_min_idx;
        r_min_stamp <= w_take_min ? r_stamp : i_min_stamp;
        r_min_key   <= w_take_min ? r_key   : i_min_key;
    end

    assign o_flags     = r_flags;
    assign o_key       = r_tok_key;
    assign o_match_idx = r_match_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_min_idx   = r_min_idx;
    assign o_min_stamp = r_min_stamp;
    assign o_min_key   = r_min_key;

endmodule
